FILE: hdl/even_odd_polygon_mask_rasterizer_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the even-odd polygon mask rasteriser
// Shared property forms, written once so that every checking site reads alike.
// ----------------------------------------------------------------------------
`ifndef EVEN_ODD_POLYGON_MASK_RASTERIZER_ASSERT_SVH
`define EVEN_ODD_POLYGON_MASK_RASTERIZER_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, sampled on clk and silent while rst is high.
`define EOPM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("eopm assertion failed");
// Next-cycle implication, sampled on clk and silent while rst is high.
`define EOPM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("eopm assertion failed");
`else
`define EOPM_ASSERT_IMPL(label, ante, cons)
`define EOPM_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: hdl/eopm_pkg.sv
// ----------------------------------------------------------------------------
// eopm_pkg
// Sizes, codes and controller/datapath interface types of the rasteriser.
// ----------------------------------------------------------------------------
package eopm_pkg;

  localparam int MAX_WIDTH    = 256;
  localparam int MAX_HEIGHT   = 256;
  localparam int MAX_VERTICES = 64;

  // Fixed field widths.
  localparam int CRDW  = 24;   // signed Q16.8 coordinate
  localparam int TSW   = 23;   // unsigned Q15.8 size
  localparam int DIMW  = 9;    // used mask size register
  localparam int TCW   = 8;    // texel column or row of a read
  localparam int CFGW  = 24;   // configuration data
  localparam int CFGIW = 3;    // configuration index

  // Derived widths.
  localparam int CAW  = $clog2(MAX_WIDTH);
  localparam int RAW  = $clog2(MAX_HEIGHT);
  localparam int VAW  = $clog2(MAX_VERTICES);
  localparam int XW   = $clog2(MAX_WIDTH + 1);
  localparam int YW   = $clog2(MAX_HEIGHT + 1);
  localparam int CNTW = $clog2(MAX_VERTICES + 1);
  localparam int POSW = CRDW + 1;                  // corner plus extent
  localparam int NW   = POSW + 1;                  // span numerator
  localparam int IW   = ((CAW > RAW) ? CAW : RAW) + 1;  // 2*i+1
  localparam int PW   = IW + TSW + 2;              // doubled sample point
  localparam int DW   = PW + 1;                    // long edge difference
  localparam int SW   = CRDW + 2;                  // short edge difference
  localparam int MLO  = 18;                        // low partial product slice

  typedef enum logic [2:0] {
    OP_CLEAR      = 3'd0,
    OP_FILL       = 3'd1,
    OP_ADD_VERTEX = 3'd2,
    OP_RASTER     = 3'd3,
    OP_READ       = 3'd4
  } op_t;

  localparam logic [CFGIW-1:0] REG_ORIGIN_X    = 3'd0;
  localparam logic [CFGIW-1:0] REG_ORIGIN_Y    = 3'd1;
  localparam logic [CFGIW-1:0] REG_TEXEL_SIZE  = 3'd2;
  localparam logic [CFGIW-1:0] REG_MASK_WIDTH  = 3'd3;
  localparam logic [CFGIW-1:0] REG_MASK_HEIGHT = 3'd4;

  localparam logic [1:0] SPAN_X_LO = 2'd0;
  localparam logic [1:0] SPAN_X_HI = 2'd1;
  localparam logic [1:0] SPAN_Y_LO = 2'd2;
  localparam logic [1:0] SPAN_Y_HI = 2'd3;

  typedef struct packed {
    logic load_in;
    logic vert_add;
    logic cnt_clear;
    logic y_zero;
    logic y_from_span;
    logic y_inc;
    logic x_from_span;
    logic x_inc;
    logic clr_wr;
    logic fill_wr;
    logic buf_wr;
    logic row_rd_texel;
    logic span_reset;
    logic div_start;
    logic vp_zero;
    logic vp_inc;
    logic e_zero;
    logic e_inc;
    logic bb_update;
    logic prod_x;
    logic prod_y;
    logic px_set;
    logic py_set;
    logic prev_load;
    logic diff_load;
    logic in_zero;
    logic edge_cmp;
    logic rowbuf_load;
    logic rowbuf_set;
    logic read_done;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic span_last;
    logic y_clr_last;
    logic y_end;
    logic x_end;
    logic cnt_zero;
    logic e_last;
  } dp_sts_t;

endpackage

FILE: hdl/even_odd_polygon_mask_rasterizer.sv
// ----------------------------------------------------------------------------
// even_odd_polygon_mask_rasterizer
// One-bit coverage mask over a texel grid, filled by rectangles and by
// even-odd polygons in signed Q16.8 world coordinates.
// ----------------------------------------------------------------------------
// A command word is taken at a rising edge where start is high and busy is
// low. Every command, including an unused opcode, gives exactly one result
// word: done is high for a single cycle, with covered and status valid in that
// cycle only, and the receiver cannot hold it off. After reset the block
// clears its mask one row per cycle, and busy stays high until all 256 rows
// are clear, before the first command is taken; configuration writes are
// taken at any time but should only be made while busy is low and no result
// is outstanding. Add vertex and unused opcodes go straight to the result,
// read texel reads the addressed row, and clear writes one row per cycle.
// Fill rectangle runs its four span divisions (a shared divider producing
// one quotient bit per cycle over 26 bits) and then writes each row of the
// rectangle. With vertices stored, rasterise reads each for the bounding
// box, runs the same span divisions and then tests each texel of each row
// against every edge: each edge passes through a two-stage multiplier pair
// before its crossing compare; the vertex memory is read one entry per edge.
// ----------------------------------------------------------------------------
`include "even_odd_polygon_mask_rasterizer_assert.svh"

module even_odd_polygon_mask_rasterizer (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic [2:0]                       opcode,
  input  logic signed [eopm_pkg::CRDW-1:0] pos_x,
  input  logic signed [eopm_pkg::CRDW-1:0] pos_y,
  input  logic [eopm_pkg::TSW-1:0]         size_x,
  input  logic [eopm_pkg::TSW-1:0]         size_y,
  input  logic [eopm_pkg::TCW-1:0]         texel_col,
  input  logic [eopm_pkg::TCW-1:0]         texel_row,
  output logic                             done,
  output logic                             covered,
  output logic                             status,
  input  logic                             wr_en,
  input  logic [eopm_pkg::CFGIW-1:0]       wr_index,
  input  logic [eopm_pkg::CFGW-1:0]        wr_data
);
  import eopm_pkg::*;

  // The sequencer and the datapath talk only through these two bundles.
  dp_cmd_t cmd;
  dp_sts_t sts;

  // The sequencer decodes the opcode at acceptance and walks the command:
  // clearing rows, running span divisions, stepping rows, texels and edges.
  eopm_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .opcode (opcode),
    .sts    (sts),
    .cmd    (cmd),
    .busy   (busy)
  );

  // The datapath holds the configuration registers, the mask memory (one
  // row of texels per word), the vertex store, the divider and the edge
  // multipliers, and registers the result word.
  eopm_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .size_x    (size_x),
    .size_y    (size_y),
    .texel_col (texel_col),
    .texel_row (texel_row),
    .cmd       (cmd),
    .sts       (sts),
    .done      (done),
    .covered   (covered),
    .status    (status)
  );

  // A result is shown only once the sequencer has gone back to idle.
  `EOPM_ASSERT_IMPL(a_done_when_idle, done, !busy)
  // An accepted command always occupies the block in the following cycle.
  `EOPM_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  // Result flags never appear outside the result cycle.
  `EOPM_ASSERT_IMPL(a_flags_with_done, covered || status, done)

endmodule

FILE: hdl/eopm_div.sv
// ----------------------------------------------------------------------------
// eopm_div
// Restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module eopm_div (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [eopm_pkg::NW-1:0] num,
  input  logic [eopm_pkg::TSW-1:0] den,
  output logic                    done,
  output logic [eopm_pkg::NW-1:0] quo,
  output logic                    rem_nz
);
  import eopm_pkg::*;

  localparam int CW = $clog2(NW + 1);

  logic           active;
  logic [CW-1:0]  cnt;
  logic [TSW-1:0] rem;
  logic [TSW-1:0] dsr;
  logic [TSW:0]   trial;
  logic           qbit;

  assign trial  = {rem, quo[NW-1]};
  assign qbit   = (trial >= {1'b0, dsr});
  assign rem_nz = (rem != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      cnt    <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        cnt    <= CW'(NW);
      end else if (active) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= num;
      dsr <= den;
    end else if (active) begin
      rem <= qbit ? TSW'(trial - {1'b0, dsr}) : trial[TSW-1:0];
      quo <= {quo[NW-2:0], qbit};
    end
  end

endmodule

FILE: hdl/eopm_mul.sv
// ----------------------------------------------------------------------------
// eopm_mul
// Two-stage signed multiplier built from two narrow partial products.
// ----------------------------------------------------------------------------
module eopm_mul (
  input  logic                              clk,
  input  logic signed [eopm_pkg::DW-1:0]    a,
  input  logic signed [eopm_pkg::SW-1:0]    b,
  output logic signed [eopm_pkg::DW+eopm_pkg::SW-1:0] p
);
  import eopm_pkg::*;

  localparam int PRW = DW + SW;

  logic signed [MLO+SW:0]       plo;
  logic signed [DW-MLO+SW-1:0]  phi;

  always_ff @(posedge clk) begin
    plo <= $signed({1'b0, a[MLO-1:0]}) * b;
    phi <= $signed(a[DW-1:MLO]) * b;
    p   <= (PRW'(phi) <<< MLO) + PRW'(plo);
  end

endmodule

FILE: hdl/eopm_dp.sv
// ----------------------------------------------------------------------------
// eopm_dp
// Datapath: configuration, mask and vertex memories, span and edge arithmetic.
// ----------------------------------------------------------------------------
module eopm_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            wr_en,
  input  logic [eopm_pkg::CFGIW-1:0]      wr_index,
  input  logic [eopm_pkg::CFGW-1:0]       wr_data,
  input  logic signed [eopm_pkg::CRDW-1:0] pos_x,
  input  logic signed [eopm_pkg::CRDW-1:0] pos_y,
  input  logic [eopm_pkg::TSW-1:0]        size_x,
  input  logic [eopm_pkg::TSW-1:0]        size_y,
  input  logic [eopm_pkg::TCW-1:0]        texel_col,
  input  logic [eopm_pkg::TCW-1:0]        texel_row,
  input  eopm_pkg::dp_cmd_t               cmd,
  output eopm_pkg::dp_sts_t               sts,
  output logic                            done,
  output logic                            covered,
  output logic                            status
);
  import eopm_pkg::*;

  localparam int LW  = (XW > YW) ? XW : YW;
  localparam int UWC = (DIMW > LW) ? DIMW : LW;
  localparam int VW  = NW + 1;

  // Configuration.
  logic signed [CRDW-1:0] ox, oy;
  logic [TSW-1:0]         tsz_r, tsz;
  logic [DIMW-1:0]        mw, mh;
  logic [UWC-1:0]         used_w, used_h;

  // Latched command fields and results.
  logic signed [POSW-1:0] bx_lo, bx_hi, by_lo, by_hi;
  logic [TCW-1:0]         tcol, trow;
  logic [15:0]            tcol_w, trow_w;
  logic                   cov_r, stat_r;

  // Spans and walk counters.
  logic [1:0]             sel;
  logic [XW-1:0]          x0, x1, x;
  logic [YW-1:0]          y0, y1, y;

  // Span division.
  logic signed [POSW-1:0] bound;
  logic signed [CRDW-1:0] org;
  logic signed [NW-1:0]   n;
  logic [NW-1:0]          mag;
  logic                   neg;
  logic [UWC-1:0]         lim;
  logic                   div_done;
  logic [NW-1:0]          quo;
  logic                   rem_nz;
  logic [VW-1:0]          qv, span_v;

  // Mask memory.
  logic [MAX_WIDTH-1:0]   mask_mem [MAX_HEIGHT];
  logic [MAX_WIDTH-1:0]   mrdata, wdata, fmask, rowbuf;
  logic [RAW-1:0]         raddr, waddr;
  logic                   mem_we;

  // Vertex store.
  logic signed [CRDW-1:0] vx_mem [MAX_VERTICES];
  logic signed [CRDW-1:0] vy_mem [MAX_VERTICES];
  logic signed [CRDW-1:0] vx_q, vy_q, prev_x, prev_y;
  logic [CNTW-1:0]        cnt, ecnt;
  logic [VAW-1:0]         vptr, vptr_next, vptr_wrap;

  // Edge test.
  logic [IW-1:0]          odd;
  logic [IW+TSW-1:0]      prod;
  logic signed [PW-1:0]   px2, py2;
  logic signed [POSW-1:0] ax2, ay2, bx2, by2;
  logic signed [DW-1:0]   dax, dpy;
  logic signed [SW-1:0]   dy, dbx;
  logic                   straddle, in_poly, tog;
  logic signed [DW+SW-1:0] lhs, rhs;

  assign tsz    = (tsz_r == '0) ? TSW'(1) : tsz_r;
  assign used_w = (UWC'(mw) > UWC'(MAX_WIDTH))  ? UWC'(MAX_WIDTH)  : UWC'(mw);
  assign used_h = (UWC'(mh) > UWC'(MAX_HEIGHT)) ? UWC'(MAX_HEIGHT) : UWC'(mh);
  assign tcol_w = 16'(tcol);
  assign trow_w = 16'(trow);

  always_ff @(posedge clk) begin
    if (rst) begin
      ox    <= '0;
      oy    <= '0;
      tsz_r <= TSW'(256);
      mw    <= DIMW'(256);
      mh    <= DIMW'(256);
    end else if (wr_en) begin
      unique case (wr_index)
        REG_ORIGIN_X:    ox    <= wr_data;
        REG_ORIGIN_Y:    oy    <= wr_data;
        REG_TEXEL_SIZE:  tsz_r <= wr_data[TSW-1:0];
        REG_MASK_WIDTH:  mw    <= wr_data[DIMW-1:0];
        REG_MASK_HEIGHT: mh    <= wr_data[DIMW-1:0];
        default: ;
      endcase
    end
  end

  // Span operands follow the selector: low ends floor, high ends ceil.
  always_comb begin
    case (sel)
      SPAN_X_LO: bound = bx_lo;
      SPAN_X_HI: bound = bx_hi;
      SPAN_Y_LO: bound = by_lo;
      default:   bound = by_hi;
    endcase
    org    = sel[1] ? oy : ox;
    lim    = sel[1] ? used_h : used_w;
    n      = NW'(bound) - NW'(org);
    neg    = n[NW-1];
    mag    = neg ? NW'(-n) : NW'(n);
    qv     = VW'(quo) + VW'(sel[0] & rem_nz);
    span_v = neg ? '0 : ((qv > VW'(lim)) ? VW'(lim) : qv);
  end

  eopm_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.div_start),
    .num    (mag),
    .den    (tsz),
    .done   (div_done),
    .quo    (quo),
    .rem_nz (rem_nz)
  );

  always_ff @(posedge clk) begin
    if (div_done) begin
      case (sel)
        SPAN_X_LO: x0 <= XW'(span_v);
        SPAN_X_HI: x1 <= XW'(span_v);
        SPAN_Y_LO: y0 <= YW'(span_v);
        default:   y1 <= YW'(span_v);
      endcase
    end
  end

  // Fill pattern of one row.
  always_comb begin
    for (int c = 0; c < MAX_WIDTH; c++) begin
      fmask[c] = (XW'(c) >= x0) && (XW'(c) < x1);
    end
  end

  assign raddr  = cmd.row_rd_texel ? trow_w[RAW-1:0] : y[RAW-1:0];
  assign waddr  = y[RAW-1:0];
  assign mem_we = cmd.clr_wr | cmd.fill_wr | cmd.buf_wr;

  always_comb begin
    if (cmd.fill_wr) begin
      wdata = mrdata | fmask;
    end else if (cmd.buf_wr) begin
      wdata = rowbuf;
    end else begin
      wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mask_mem[waddr] <= wdata;
    end
    mrdata <= mask_mem[raddr];
  end

  // Vertex pointer walks the store cyclically.
  assign vptr_wrap = (CNTW'(vptr) + 1'b1 == cnt) ? '0 : VAW'(vptr + 1'b1);

  always_comb begin
    if (cmd.vp_zero) begin
      vptr_next = '0;
    end else if (cmd.vp_inc) begin
      vptr_next = vptr_wrap;
    end else begin
      vptr_next = vptr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vert_add && (cnt < CNTW'(MAX_VERTICES))) begin
      vx_mem[cnt[VAW-1:0]] <= pos_x;
      vy_mem[cnt[VAW-1:0]] <= pos_y;
    end
    vx_q <= vx_mem[vptr_next];
    vy_q <= vy_mem[vptr_next];
  end

  // Control counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      ecnt <= '0;
      vptr <= '0;
      sel  <= '0;
      x    <= '0;
      y    <= '0;
    end else begin
      vptr <= vptr_next;
      if (cmd.cnt_clear) begin
        cnt <= '0;
      end else if (cmd.vert_add && (cnt < CNTW'(MAX_VERTICES))) begin
        cnt <= cnt + 1'b1;
      end
      if (cmd.e_zero) begin
        ecnt <= '0;
      end else if (cmd.e_inc) begin
        ecnt <= ecnt + 1'b1;
      end
      if (cmd.span_reset) begin
        sel <= '0;
      end else if (div_done) begin
        sel <= sel + 1'b1;
      end
      if (cmd.y_zero) begin
        y <= '0;
      end else if (cmd.y_from_span) begin
        y <= y0;
      end else if (cmd.y_inc) begin
        y <= y + 1'b1;
      end
      if (cmd.x_from_span) begin
        x <= x0;
      end else if (cmd.x_inc) begin
        x <= x + 1'b1;
      end
    end
  end

  // Command fields, bounding box and result flags. A vertex offered to a full
  // store is flagged in stat_r, which is latched as the command is taken.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      bx_lo  <= POSW'(pos_x);
      bx_hi  <= POSW'(pos_x) + $signed({2'b00, size_x});
      by_lo  <= POSW'(pos_y);
      by_hi  <= POSW'(pos_y) + $signed({2'b00, size_y});
      tcol   <= texel_col;
      trow   <= texel_row;
      cov_r  <= 1'b0;
      stat_r <= cmd.vert_add && (cnt == CNTW'(MAX_VERTICES));
    end else begin
      if (cmd.bb_update) begin
        if (ecnt == '0) begin
          bx_lo <= POSW'(vx_q);
          bx_hi <= POSW'(vx_q);
          by_lo <= POSW'(vy_q);
          by_hi <= POSW'(vy_q);
        end else begin
          if (POSW'(vx_q) < bx_lo) bx_lo <= POSW'(vx_q);
          if (POSW'(vx_q) > bx_hi) bx_hi <= POSW'(vx_q);
          if (POSW'(vy_q) < by_lo) by_lo <= POSW'(vy_q);
          if (POSW'(vy_q) > by_hi) by_hi <= POSW'(vy_q);
        end
      end
      if (cmd.read_done) begin
        cov_r <= (UWC'(tcol) < used_w) && (UWC'(trow) < used_h) &&
                 mrdata[tcol_w[CAW-1:0]];
      end
    end
  end

  // Sample point at doubled scale: 2*origin + (2*i + 1)*texel.
  assign odd = cmd.prod_y ? {(IW-1)'(y[RAW-1:0]), 1'b1} : {(IW-1)'(x[CAW-1:0]), 1'b1};

  always_ff @(posedge clk) begin
    if (cmd.prod_x || cmd.prod_y) begin
      prod <= odd * tsz;
    end
    if (cmd.px_set) begin
      px2 <= PW'($signed({ox, 1'b0})) + $signed({2'b00, prod});
    end
    if (cmd.py_set) begin
      py2 <= PW'($signed({oy, 1'b0})) + $signed({2'b00, prod});
    end
  end

  // Edge from the previous vertex (a) to the one just read (b).
  assign ax2 = {prev_x, 1'b0};
  assign ay2 = {prev_y, 1'b0};
  assign bx2 = {vx_q, 1'b0};
  assign by2 = {vy_q, 1'b0};

  always_ff @(posedge clk) begin
    if (cmd.prev_load) begin
      prev_x <= vx_q;
      prev_y <= vy_q;
    end
    if (cmd.diff_load) begin
      straddle <= ((PW'(ay2) > py2) != (PW'(by2) > py2));
      dy       <= SW'(by2) - SW'(ay2);
      dbx      <= SW'(bx2) - SW'(ax2);
      dax      <= DW'(px2) - DW'(ax2);
      dpy      <= DW'(py2) - DW'(ay2);
    end
  end

  eopm_mul u_mul_lhs (.clk(clk), .a(dax), .b(dy),  .p(lhs));
  eopm_mul u_mul_rhs (.clk(clk), .a(dpy), .b(dbx), .p(rhs));

  assign tog = straddle && ((dy > 0) ? (lhs < rhs) : (lhs > rhs));

  always_ff @(posedge clk) begin
    if (cmd.in_zero) begin
      in_poly <= 1'b0;
    end else if (cmd.edge_cmp) begin
      in_poly <= in_poly ^ tog;
    end
    if (cmd.rowbuf_load) begin
      rowbuf <= mrdata;
    end else if (cmd.rowbuf_set && in_poly) begin
      rowbuf[x[CAW-1:0]] <= 1'b1;
    end
  end

  // Result word, shown for one cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      done    <= 1'b0;
      covered <= 1'b0;
      status  <= 1'b0;
    end else begin
      done    <= cmd.finish;
      covered <= cmd.finish & cov_r;
      status  <= cmd.finish & stat_r;
    end
  end

  assign sts.div_done   = div_done;
  assign sts.span_last  = (sel == SPAN_Y_HI);
  assign sts.y_clr_last = (y == YW'(MAX_HEIGHT - 1));
  assign sts.y_end      = (y >= y1);
  assign sts.x_end      = (x >= x1);
  assign sts.cnt_zero   = (cnt == '0);
  assign sts.e_last     = (ecnt == cnt - 1'b1);

endmodule

FILE: hdl/eopm_ctrl.sv
// ----------------------------------------------------------------------------
// eopm_ctrl
// Command sequencer: decodes each command and steps the datapath through it.
// ----------------------------------------------------------------------------
module eopm_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [2:0]        opcode,
  input  eopm_pkg::dp_sts_t sts,
  output eopm_pkg::dp_cmd_t cmd,
  output logic              busy
);
  import eopm_pkg::*;

  typedef enum logic [19:0] {
    S_IDLE      = 20'h00001,
    S_INIT      = 20'h00002,
    S_CLR       = 20'h00004,
    S_FIN       = 20'h00008,
    S_SPAN_GO   = 20'h00010,
    S_SPAN_WAIT = 20'h00020,
    S_FR_CHK    = 20'h00040,
    S_FR_WR     = 20'h00080,
    S_BB        = 20'h00100,
    S_PR_CHK    = 20'h00200,
    S_PR_ROW    = 20'h00400,
    S_PX_CHK    = 20'h00800,
    S_PX_SETUP  = 20'h01000,
    S_E_DIFF    = 20'h02000,
    S_E_MUL1    = 20'h04000,
    S_E_MUL2    = 20'h08000,
    S_E_CMP     = 20'h10000,
    S_PX_SET    = 20'h20000,
    S_RD        = 20'h40000,
    S_RD2       = 20'h80000
  } state_t;

  state_t state, state_next;
  logic   is_fill, is_fill_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_INIT;
      is_fill <= 1'b0;
    end else begin
      state   <= state_next;
      is_fill <= is_fill_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    cmd          = '0;
    state_next   = state;
    is_fill_next = is_fill;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_in    = 1'b1;
          cmd.span_reset = 1'b1;
          unique case (op_t'(opcode))
            OP_CLEAR: begin
              cmd.y_zero = 1'b1;
              state_next = S_CLR;
            end
            OP_FILL: begin
              is_fill_next = 1'b1;
              state_next   = S_SPAN_GO;
            end
            OP_ADD_VERTEX: begin
              cmd.vert_add = 1'b1;
              state_next   = S_FIN;
            end
            OP_RASTER: begin
              is_fill_next = 1'b0;
              if (sts.cnt_zero) begin
                state_next = S_FIN;
              end else begin
                cmd.vp_zero = 1'b1;
                cmd.e_zero  = 1'b1;
                state_next  = S_BB;
              end
            end
            OP_READ: begin
              state_next = S_RD;
            end
            default: begin
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_INIT: begin
        cmd.clr_wr = 1'b1;
        cmd.y_inc  = 1'b1;
        if (sts.y_clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_CLR: begin
        cmd.clr_wr = 1'b1;
        cmd.y_inc  = 1'b1;
        if (sts.y_clr_last) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_next = S_IDLE;
      end
      S_BB: begin
        cmd.bb_update = 1'b1;
        cmd.vp_inc    = 1'b1;
        cmd.e_inc     = 1'b1;
        if (sts.e_last) begin
          state_next = S_SPAN_GO;
        end
      end
      S_SPAN_GO: begin
        cmd.div_start = 1'b1;
        state_next    = S_SPAN_WAIT;
      end
      S_SPAN_WAIT: begin
        if (sts.div_done) begin
          if (sts.span_last) begin
            cmd.y_from_span = 1'b1;
            state_next      = is_fill ? S_FR_CHK : S_PR_CHK;
          end else begin
            state_next = S_SPAN_GO;
          end
        end
      end
      S_FR_CHK: begin
        state_next = sts.y_end ? S_FIN : S_FR_WR;
      end
      S_FR_WR: begin
        cmd.fill_wr = 1'b1;
        cmd.y_inc   = 1'b1;
        state_next  = S_FR_CHK;
      end
      S_PR_CHK: begin
        if (sts.y_end) begin
          cmd.cnt_clear = 1'b1;
          state_next    = S_FIN;
        end else begin
          cmd.prod_y = 1'b1;
          state_next = S_PR_ROW;
        end
      end
      S_PR_ROW: begin
        cmd.rowbuf_load = 1'b1;
        cmd.py_set      = 1'b1;
        cmd.x_from_span = 1'b1;
        state_next      = S_PX_CHK;
      end
      S_PX_CHK: begin
        if (sts.x_end) begin
          cmd.buf_wr = 1'b1;
          cmd.y_inc  = 1'b1;
          state_next = S_PR_CHK;
        end else begin
          cmd.prod_x  = 1'b1;
          cmd.vp_zero = 1'b1;
          cmd.e_zero  = 1'b1;
          cmd.in_zero = 1'b1;
          state_next  = S_PX_SETUP;
        end
      end
      S_PX_SETUP: begin
        cmd.px_set    = 1'b1;
        cmd.prev_load = 1'b1;
        cmd.vp_inc    = 1'b1;
        state_next    = S_E_DIFF;
      end
      S_E_DIFF: begin
        cmd.diff_load = 1'b1;
        cmd.prev_load = 1'b1;
        state_next    = S_E_MUL1;
      end
      S_E_MUL1: begin
        state_next = S_E_MUL2;
      end
      S_E_MUL2: begin
        state_next = S_E_CMP;
      end
      S_E_CMP: begin
        cmd.edge_cmp = 1'b1;
        if (sts.e_last) begin
          state_next = S_PX_SET;
        end else begin
          cmd.e_inc  = 1'b1;
          cmd.vp_inc = 1'b1;
          state_next = S_E_DIFF;
        end
      end
      S_PX_SET: begin
        cmd.rowbuf_set = 1'b1;
        cmd.x_inc      = 1'b1;
        state_next     = S_PX_CHK;
      end
      S_RD: begin
        cmd.row_rd_texel = 1'b1;
        state_next       = S_RD2;
      end
      S_RD2: begin
        cmd.read_done = 1'b1;
        state_next    = S_FIN;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
